// ===== sv/hgng_pkg.sv =====
// ----------------------------------------------------------------------------
// hgng_pkg
// Shared widths, defaults and direction codes of the hex grid neighbor
// generator.
// ----------------------------------------------------------------------------
package hgng_pkg;

   localparam int MAX_SIDE_DEFAULT = 8;
   localparam int GRID_SIDE_RESET  = 6;
   localparam int NUM_DIRS         = 6;

   localparam int COORD_W  = 4;
   localparam int NUMBER_W = 8;
   localparam int DIR_W    = 3;
   localparam int SIDE_W   = 4;

   typedef enum logic [DIR_W-1:0] {
      DIR_LEFT        = 3'd0,
      DIR_RIGHT       = 3'd1,
      DIR_UPPER_LEFT  = 3'd2,
      DIR_UPPER_RIGHT = 3'd3,
      DIR_LOWER_LEFT  = 3'd4,
      DIR_LOWER_RIGHT = 3'd5
   } dir_type;

endpackage

// ===== sv/hgng_req_if.sv =====
// ----------------------------------------------------------------------------
// hgng_req_if
// Query channel: one cell position per transaction.
// ----------------------------------------------------------------------------
interface hgng_req_if
   import hgng_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cell_row;
   logic [COORD_W-1:0] cell_col;

   modport source (output valid, output cell_row, output cell_col, input ready);
   modport sink   (input valid, input cell_row, input cell_col, output ready);
endinterface

// ===== sv/hgng_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hgng_rsp_if
// Result channel: one neighbor (or a not-found marker) per transaction.
// ----------------------------------------------------------------------------
interface hgng_rsp_if
   import hgng_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  neighbor_row;
   logic [COORD_W-1:0]  neighbor_col;
   logic [NUMBER_W-1:0] neighbor_number;
   logic [DIR_W-1:0]    direction;
   logic                found;
   logic                last;

   modport source (output valid, output neighbor_row, output neighbor_col,
                   output neighbor_number, output direction, output found,
                   output last, input ready);
   modport sink   (input valid, input neighbor_row, input neighbor_col,
                   input neighbor_number, input direction, input found,
                   input last, output ready);
endinterface

// ===== sv/hgng_csr_if.sv =====
// ----------------------------------------------------------------------------
// hgng_csr_if
// Configuration write channel for the grid side register.
// ----------------------------------------------------------------------------
interface hgng_csr_if
   import hgng_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] grid_side;

   modport source (output valid, output grid_side, input ready);
   modport sink   (input valid, input grid_side, output ready);
endinterface

// ===== sv/hgng_ram.sv =====
// ----------------------------------------------------------------------------
// hgng_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hgng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read while stalled
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hex_grid_neighbor_generator_core.sv =====
// ----------------------------------------------------------------------------
// hex_grid_neighbor_generator_core
// Neighbor enumeration on a hexagon-shaped honeycomb grid of side n.
// ----------------------------------------------------------------------------
// Each query (row, column) yields one result per neighbor that lies inside the
// grid, in the order left, right, upper-left, upper-right, lower-left,
// lower-right, with last set on the final one; a query without neighbors
// yields a single result with found low, so a query has one to six results.
// Results leave at one per cycle while the result channel is ready, and the
// next query is taken in the cycle the previous one issues its final result;
// the row-start table lives in a one-read, one-write RAM that is read once per
// result. After reset and after every write of grid_side the table is rebuilt
// in a sweep during which no query is accepted. The side is clamped to the
// range 1..MAX_SIDE.
module hex_grid_neighbor_generator_core
   import hgng_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   hgng_req_if.sink     req_if,
   hgng_rsp_if.source   rsp_if,
   hgng_csr_if.sink     csr_if
);

   localparam int ROWS  = 2 * MAX_SIDE - 1;
   localparam int AW    = $clog2(ROWS);
   localparam int NW    = $clog2(MAX_SIDE + 1);
   localparam int VW    = $clog2(3 * MAX_SIDE + 16) + 1;
   localparam int RESET_SIDE = (GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIDE_RESET;

   localparam logic signed [VW-1:0] ONE_S = 1;
   localparam logic signed [VW-1:0] TWO_S = 2;

   // side register and table sweep
   logic [NW-1:0]       side_ff, side_in;
   logic                sweep_ff, sweep_in;
   logic [AW-1:0]       sweep_row_ff, sweep_row_in;
   logic [NUMBER_W-1:0] acc_ff, acc_in;

   // query held for issue
   logic                q_valid_ff, q_valid_in;
   logic [COORD_W-1:0]  q_row_ff, q_row_in;
   logic [COORD_W-1:0]  q_col_ff, q_col_in;
   logic [NUM_DIRS-1:0] done_ff, done_in;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic [COORD_W-1:0]  s1_row_ff;
   logic [NUMBER_W-1:0] s1_col_ff;
   dir_type             s1_dir_ff;
   logic                s1_found_ff;
   logic                s1_last_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [COORD_W-1:0]  rsp_col_ff;
   logic [NUMBER_W-1:0] rsp_number_ff;
   dir_type             rsp_dir_ff;
   logic                rsp_found_ff;
   logic                rsp_last_ff;

   logic signed [VW-1:0] n_s, rows_s, r_s, c_s, up_base, lo_base, sweep_cells;
   logic signed [VW-1:0] cand_r [NUM_DIRS];
   logic signed [VW-1:0] cand_c [NUM_DIRS];
   logic [NUM_DIRS-1:0]  cand_ok, pend, rest;
   logic [DIR_W-1:0]     sel_idx;
   logic                 none_found, last_pick;
   logic                 out_free, s1_free, issue, accept, csr_write;
   logic                 ram_wr_en;
   logic [NUMBER_W-1:0]  ram_wr_data, ram_rd_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [SIDE_W-1:0]    side_clamped;

   function automatic logic signed [VW-1:0] cells_in_row(
      input logic signed [VW-1:0] n,
      input logic signed [VW-1:0] r
   );
      cells_in_row = (r < n) ? (n + r) : (n + n + n - TWO_S - r);
   endfunction

   function automatic logic inside_grid(
      input logic signed [VW-1:0] n,
      input logic signed [VW-1:0] rows,
      input logic signed [VW-1:0] r,
      input logic signed [VW-1:0] c
   );
      inside_grid = (r >= 0) && (r < rows) && (c >= 0) && (c < cells_in_row(n, r));
   endfunction

   assign n_s    = VW'(side_ff);
   assign rows_s = n_s + n_s - ONE_S;
   assign r_s    = VW'(q_row_ff);
   assign c_s    = VW'(q_col_ff);

   // ------------------------------------------------------------------
   // candidates of the held query
   // ------------------------------------------------------------------
   always_comb begin
      up_base = (r_s < n_s) ? (c_s - ONE_S) : c_s;
      lo_base = (r_s < n_s - ONE_S) ? c_s : (c_s - ONE_S);
      cand_r[DIR_LEFT]        = r_s;
      cand_c[DIR_LEFT]        = c_s - ONE_S;
      cand_r[DIR_RIGHT]       = r_s;
      cand_c[DIR_RIGHT]       = c_s + ONE_S;
      cand_r[DIR_UPPER_LEFT]  = r_s - ONE_S;
      cand_c[DIR_UPPER_LEFT]  = up_base;
      cand_r[DIR_UPPER_RIGHT] = r_s - ONE_S;
      cand_c[DIR_UPPER_RIGHT] = up_base + ONE_S;
      cand_r[DIR_LOWER_LEFT]  = r_s + ONE_S;
      cand_c[DIR_LOWER_LEFT]  = lo_base;
      cand_r[DIR_LOWER_RIGHT] = r_s + ONE_S;
      cand_c[DIR_LOWER_RIGHT] = lo_base + ONE_S;
      for (int i = 0; i < NUM_DIRS; i++) begin
         cand_ok[i] = inside_grid(n_s, rows_s, cand_r[i], cand_c[i]);
      end
   end

   // pick the lowest pending direction
   always_comb begin
      pend    = cand_ok & ~done_ff;
      sel_idx = '0;
      for (int i = NUM_DIRS - 1; i >= 0; i--) begin
         if (pend[i]) begin
            sel_idx = DIR_W'(i);
         end
      end
      rest       = pend & ~(NUM_DIRS'(1) << sel_idx);
      none_found = (cand_ok == '0);
      last_pick  = (rest == '0);
   end

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign s1_free        = !s1_valid_ff || out_free;
   assign issue          = q_valid_ff && s1_free;
   assign req_if.ready   = !sweep_ff && (!q_valid_ff || (issue && last_pick));
   assign accept         = req_if.valid && req_if.ready;
   assign csr_if.ready   = 1'b1;
   assign csr_write      = csr_if.valid;

   always_comb begin
      side_clamped = csr_if.grid_side;
      if (csr_if.grid_side == '0) begin
         side_clamped = SIDE_W'(1);
      end else if ({4'b0, csr_if.grid_side} > 8'(MAX_SIDE)) begin
         side_clamped = SIDE_W'(MAX_SIDE);
      end
   end

   // ------------------------------------------------------------------
   // row-start table sweep
   // ------------------------------------------------------------------
   always_comb begin
      sweep_cells  = cells_in_row(n_s, VW'(sweep_row_ff));
      ram_wr_en    = sweep_ff;
      ram_wr_data  = (VW'(sweep_row_ff) < rows_s) ? acc_ff : '0;
      side_in      = side_ff;
      sweep_in     = sweep_ff;
      sweep_row_in = sweep_row_ff;
      acc_in       = acc_ff;
      if (csr_write) begin
         // restart the sweep for the new side
         side_in      = NW'(side_clamped);
         sweep_in     = 1'b1;
         sweep_row_in = '0;
         acc_in       = '0;
      end else if (sweep_ff) begin
         acc_in       = acc_ff + NUMBER_W'(sweep_cells);
         sweep_row_in = sweep_row_ff + AW'(1);
         if (sweep_row_ff == AW'(ROWS - 1)) begin
            sweep_in = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // query hold and issue
   // ------------------------------------------------------------------
   always_comb begin
      q_valid_in = q_valid_ff;
      q_row_in   = q_row_ff;
      q_col_in   = q_col_ff;
      done_in    = done_ff;
      if (issue) begin
         done_in = done_ff | (NUM_DIRS'(1) << sel_idx);
         if (last_pick) begin
            q_valid_in = 1'b0;
         end
      end
      if (accept) begin
         q_valid_in = 1'b1;
         q_row_in   = req_if.cell_row;
         q_col_in   = req_if.cell_col;
         done_in    = '0;
      end
   end

   assign ram_rd_addr = AW'(cand_r[sel_idx]);

   hgng_ram #(
      .WIDTH (NUMBER_W),
      .DEPTH (ROWS)
   ) u_row_start (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sweep_row_ff),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (out_free) begin
         s1_valid_in = 1'b0;
      end
      if (issue) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= NW'(RESET_SIDE);
         sweep_ff     <= 1'b1;
         sweep_row_ff <= '0;
         acc_ff       <= '0;
         q_valid_ff   <= 1'b0;
         done_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff      <= side_in;
         sweep_ff     <= sweep_in;
         sweep_row_ff <= sweep_row_in;
         acc_ff       <= acc_in;
         q_valid_ff   <= q_valid_in;
         done_ff      <= done_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_row_ff <= q_row_in;
      q_col_ff <= q_col_in;
      if (issue) begin
         if (none_found) begin
            s1_row_ff   <= '0;
            s1_col_ff   <= '0;
            s1_dir_ff   <= DIR_LEFT;
            s1_found_ff <= 1'b0;
            s1_last_ff  <= 1'b1;
         end else begin
            s1_row_ff   <= COORD_W'(cand_r[sel_idx]);
            s1_col_ff   <= NUMBER_W'(cand_c[sel_idx]);
            s1_dir_ff   <= dir_type'(sel_idx);
            s1_found_ff <= 1'b1;
            s1_last_ff  <= last_pick;
         end
      end
      if (s1_valid_ff && out_free) begin
         rsp_row_ff    <= s1_row_ff;
         rsp_col_ff    <= s1_col_ff[COORD_W-1:0];
         rsp_number_ff <= s1_found_ff ? (ram_rd_data + s1_col_ff) : '0;
         rsp_dir_ff    <= s1_dir_ff;
         rsp_found_ff  <= s1_found_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.neighbor_row    = rsp_row_ff;
   assign rsp_if.neighbor_col    = rsp_col_ff;
   assign rsp_if.neighbor_number = rsp_number_ff;
   assign rsp_if.direction       = rsp_dir_ff;
   assign rsp_if.found           = rsp_found_ff;
   assign rsp_if.last            = rsp_last_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex grid neighbor generator. Cell queries go in
// on the request channel and the grid side is changed between phases through
// the CSR write channel. A scoreboard predicts every neighbor result from its
// own copy of the side and row-start table and checks the result stream in
// order, field by field, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import hgng_pkg::*;

   localparam int GRID_MAX     = MAX_SIDE_DEFAULT;
   localparam int ROW_SLOTS    = 2 * GRID_MAX - 1;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 2 * GRID_MAX + 8;
   localparam int SEG_QUERIES  = 17;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [NUMBER_W-1:0] number;
      dir_type             direction;
      logic                found;
      logic                last;
   } neighbor_type;

   class neighbor_scoreboard;
      int                  side;
      logic [NUMBER_W-1:0] row_start [ROW_SLOTS];
      neighbor_type        neighbor_q [$];
      int unsigned         failures;

      function new();
         failures = 0;
         load_side(SIDE_W'(GRID_SIDE_RESET));
      endfunction

      function int row_length(int r);
         return (r < side) ? side + r : 3 * side - 2 - r;
      endfunction

      function bit on_grid(int r, int c);
         if (r < 0 || r >= 2 * side - 1)
            return 1'b0;
         return (c >= 0 && c < row_length(r));
      endfunction

      function int pending();
         return neighbor_q.size();
      endfunction

      // Clamp the side and rebuild the first-cell number of every row.
      function void load_side(logic [SIDE_W-1:0] value);
         int acc;
         int r;
         if (value == 0)
            side = 1;
         else if (value > GRID_MAX)
            side = GRID_MAX;
         else
            side = int'(value);
         acc = 0;
         for (r = 0; r < ROW_SLOTS; r++) begin
            if (r < 2 * side - 1) begin
               row_start[r] = acc[NUMBER_W-1:0];
               acc += row_length(r);
            end else begin
               row_start[r] = '0;
            end
         end
      endfunction

      function void note_query(logic [COORD_W-1:0] cell_row, logic [COORD_W-1:0] cell_col);
         int           r;
         int           c;
         int           i;
         int           sum;
         int           last_dir;
         int           nr [NUM_DIRS];
         int           nc [NUM_DIRS];
         neighbor_type item;
         r = int'(cell_row);
         c = int'(cell_col);
         nr[DIR_LEFT]        = r;     nc[DIR_LEFT]        = c - 1;
         nr[DIR_RIGHT]       = r;     nc[DIR_RIGHT]       = c + 1;
         nr[DIR_UPPER_LEFT]  = r - 1; nc[DIR_UPPER_LEFT]  = (r < side) ? c - 1 : c;
         nr[DIR_UPPER_RIGHT] = r - 1; nc[DIR_UPPER_RIGHT] = nc[DIR_UPPER_LEFT] + 1;
         nr[DIR_LOWER_LEFT]  = r + 1; nc[DIR_LOWER_LEFT]  = (r < side - 1) ? c : c - 1;
         nr[DIR_LOWER_RIGHT] = r + 1; nc[DIR_LOWER_RIGHT] = nc[DIR_LOWER_LEFT] + 1;
         last_dir = -1;
         for (i = 0; i < NUM_DIRS; i++)
            if (on_grid(nr[i], nc[i]))
               last_dir = i;
         if (last_dir < 0) begin
            item.row       = '0;
            item.col       = '0;
            item.number    = '0;
            item.direction = DIR_LEFT;
            item.found     = 1'b0;
            item.last      = 1'b1;
            neighbor_q.push_back(item);
         end else begin
            for (i = 0; i <= last_dir; i++) begin
               if (on_grid(nr[i], nc[i])) begin
                  sum            = int'(row_start[nr[i]]) + nc[i];
                  item.row       = nr[i][COORD_W-1:0];
                  item.col       = nc[i][COORD_W-1:0];
                  item.number    = sum[NUMBER_W-1:0];
                  item.direction = dir_type'(i[DIR_W-1:0]);
                  item.found     = 1'b1;
                  item.last      = (i == last_dir);
                  neighbor_q.push_back(item);
               end
            end
         end
      endfunction

      function void check_result(neighbor_type got);
         neighbor_type want;
         if (neighbor_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result: row %0d col %0d num %0d dir %0d found %0b last %0b",
                        got.row, got.col, got.number, got.direction, got.found, got.last);
            return;
         end
         want = neighbor_q.pop_front();
         if (got.row !== want.row || got.col !== want.col || got.number !== want.number ||
             got.direction !== want.direction || got.found !== want.found ||
             got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("mismatch: expected row %0d col %0d num %0d dir %0d found %0b last %0b",
                        want.row, want.col, want.number, want.direction, want.found,
                        want.last);
               $display("          actual   row %0d col %0d num %0d dir %0d found %0b last %0b",
                        got.row, got.col, got.number, got.direction, got.found, got.last);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hgng_req_if req_bus ();
   hgng_rsp_if rsp_bus ();
   hgng_csr_if csr_bus ();

   neighbor_scoreboard sb;
   neighbor_type       observed;
   int                 src_idle_pct;
   int                 snk_idle_pct;
   int                 idle_cycles;

   hex_grid_neighbor_generator_core #(
      .MAX_SIDE (GRID_MAX)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // Track every transaction on the three channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.load_side(csr_bus.grid_side);
         if (req_bus.valid && req_bus.ready)
            sb.note_query(req_bus.cell_row, req_bus.cell_col);
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed.row       = rsp_bus.neighbor_row;
            observed.col       = rsp_bus.neighbor_col;
            observed.number    = rsp_bus.neighbor_number;
            observed.direction = dir_type'(rsp_bus.direction);
            observed.found     = rsp_bus.found;
            observed.last      = rsp_bus.last;
            sb.check_result(observed);
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (reset || (csr_bus.valid && csr_bus.ready) ||
                   (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Valid stays high on return so a following query can go back to back.
   task automatic send_query(input int row, input int col);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cell_row <= row[COORD_W-1:0];
      req_bus.cell_col <= col[COORD_W-1:0];
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Write the side only once the block has drained.
   task automatic write_side(input logic [SIDE_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.grid_side <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly cells on the grid, the rest anywhere in the 4-bit field.
   task automatic random_queries(input int count);
      int k;
      int r;
      int c;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(4) == 0) begin
            r = $urandom_range(15);
            c = $urandom_range(15);
         end else begin
            r = $urandom_range(2 * sb.side - 2);
            c = $urandom_range(sb.row_length(r) - 1);
         end
         send_query(r, c);
      end
   endtask

   initial begin
      int phase;
      int seg;
      sb                = new();
      reset             = 1'b1;
      idle_cycles       = 0;
      src_idle_pct      = 13;
      snk_idle_pct      = 74;
      req_bus.valid     = 1'b0;
      req_bus.cell_row  = '0;
      req_bus.cell_col  = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.grid_side = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Side after reset: corners, middle row ends, interior, off grid.
      send_query(0, 0);
      send_query(3, 4);
      send_query(5, 0);
      send_query(5, 10);
      send_query(10, 5);
      send_query(15, 15);

      // Single-cell grid: no neighbor at all, and queries beside the grid.
      write_side(4'd1);
      send_query(0, 0);
      send_query(1, 0);
      send_query(0, 1);

      // Zero clamps up to one.
      write_side(4'd0);
      send_query(0, 0);

      // Above the maximum clamps down to it.
      write_side(4'd15);
      send_query(7, 7);
      send_query(8, 7);
      send_query(7, 0);
      send_query(7, 14);
      send_query(14, 0);
      send_query(14, 7);
      send_query(0, 7);
      send_query(15, 15);
      send_query(15, 0);

      write_side(GRID_MAX[SIDE_W-1:0]);
      send_query(14, 7);
      send_query(0, 0);

      write_side(4'd2);
      send_query(1, 1);
      send_query(2, 2);
      send_query(0, 1);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               src_idle_pct = 13;
               snk_idle_pct = 74;
            end
            1: begin
               src_idle_pct = 74;
               snk_idle_pct = 13;
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
            end
         endcase
         for (seg = 0; seg < 3; seg++) begin
            write_side(4'($urandom_range(15)));
            random_queries(SEG_QUERIES);
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
